FILE: design/edc_pkg.sv
// Package: payload types and constants for the extended/double converter.
`default_nettype none
package edc_pkg;
   localparam logic [14:0] EXT_EXPMAX = 15'h7fff;
   localparam logic [14:0] EXT_BIAS = 15'h3fff;
   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8000000000000;
   localparam logic [0:0] OP_EXT_TO_DBL = 1'b0;
   localparam logic [0:0] OP_DBL_TO_EXT = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [63:0] ext_significand;
      logic [15:0] ext_sign_exponent;
      logic [63:0] double_bits;
   } req_type;

   typedef struct packed {
      logic [63:0] double_result;
      logic [63:0] ext_significand_out;
      logic [15:0] ext_sign_exponent_out;
   } rsp_type;

   typedef struct packed {
      logic        op;
      logic        sign;
      logic        special;
      logic [63:0] special_val;
      logic [15:0] special_se;
      logic        zero;
      logic signed [17:0] exp;
      logic [63:0] mant;
   } norm_type;

   function automatic logic [6:0] lzc64(input logic [63:0] v);
      logic [6:0] n;
      n = 7'd64;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) n = 7'(63 - i);
      end
      return n;
   endfunction
endpackage
`default_nettype wire

FILE: design/extended_double_converter.sv
// Top level: three-stage extended/double format converter.
// An accepted item passes the classify, normalize and round registers in order to reach rsp_valid.
// Throughput: one item per cycle; the whole pipeline holds while rsp_stall is high with a valid result.
// Reset clears the stage valid bits; payload registers are not reset.
`default_nettype none
module extended_double_converter import edc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire req_type req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data
);
   logic [2:0] valid_ff, valid_in;
   logic enable;
   norm_type n1, n2;
   logic [6:0] lz1;

   assign enable = !(rsp_stall && valid_ff[2]);
   assign req_stall = !enable;
   assign rsp_valid = valid_ff[2];
   assign valid_in = {valid_ff[1:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (enable) valid_ff <= valid_in;
   end

   edc_classify u_cls (.clock, .enable, .req(req_data), .norm_ff(n1), .lz_ff(lz1));
   edc_normalize u_nrm (.clock, .enable, .norm(n1), .lz(lz1), .norm_ff(n2));
   edc_round u_rnd (.clock, .enable, .norm(n2), .rsp_ff(rsp_data));

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("item lost in pipeline");
endmodule
`default_nettype wire

FILE: design/edc_classify.sv
// Stage one: decode specials and count leading zeros.
`default_nettype none
module edc_classify import edc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     enable,
   input  wire req_type  req,
   output norm_type      norm_ff,
   output logic [6:0]    lz_ff
);
   norm_type norm_in;
   logic [6:0] lz_in;
   logic [14:0] e;
   logic [10:0] be;
   logic [51:0] f;

   always_comb begin
      norm_in = '0;
      e = req.ext_sign_exponent[14:0];
      be = req.double_bits[62:52];
      f = req.double_bits[51:0];
      norm_in.op = req.operation;
      lz_in = 7'd0;
      if (req.operation == OP_EXT_TO_DBL) begin
         norm_in.sign = req.ext_sign_exponent[15];
         norm_in.mant = req.ext_significand;
         norm_in.exp = (e == 15'd0) ? 18'sd1 : 18'(e);
         lz_in = lzc64(req.ext_significand);
         if (e != 15'd0 && !req.ext_significand[63]) begin
            norm_in.special = 1'b1;
            norm_in.special_val = DEFAULT_NAN;
         end else if (e == EXT_EXPMAX) begin
            norm_in.special = 1'b1;
            norm_in.special_val = {req.ext_sign_exponent[15], 11'h7ff,
               (req.ext_significand[62:0] == 63'd0) ? 52'd0
               : {1'b1, req.ext_significand[61:11]}};
         end else if (req.ext_significand == 64'd0) begin
            norm_in.special = 1'b1;
            norm_in.special_val = {req.ext_sign_exponent[15], 63'd0};
         end
      end else begin
         norm_in.sign = req.double_bits[63];
         norm_in.mant = {1'b0, f, 11'd0};
         norm_in.exp = 18'sd1 - 18'sd1023 + 18'(EXT_BIAS);
         lz_in = lzc64({1'b0, f, 11'd0});
         if (be == 11'h7ff) begin
            norm_in.special = 1'b1;
            norm_in.special_val = {1'b1, f[51] | (f != 52'd0), f[50:0], 11'd0};
            norm_in.special_se = {req.double_bits[63], EXT_EXPMAX};
         end else if (be == 11'd0 && f == 52'd0) begin
            norm_in.special = 1'b1;
            norm_in.special_se = {req.double_bits[63], 15'd0};
         end else if (be != 11'd0) begin
            norm_in.special = 1'b1;
            norm_in.special_val = {1'b1, f, 11'd0};
            norm_in.special_se = {req.double_bits[63],
               15'(18'(be) - 18'sd1023 + 18'(EXT_BIAS))};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         norm_ff <= norm_in;
         lz_ff <= lz_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/edc_normalize.sv
// Stage two: normalize the significand and form the target exponent.
`default_nettype none
module edc_normalize import edc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  enable,
   input  wire norm_type norm,
   input  wire logic [6:0] lz,
   output norm_type   norm_ff
);
   norm_type norm_in;

   always_comb begin
      norm_in = norm;
      norm_in.mant = norm.mant << lz[5:0];
      if (norm.op == OP_EXT_TO_DBL)
         norm_in.exp = norm.exp - 18'(lz) - 18'(EXT_BIAS) + 18'sd1023;
      else
         norm_in.exp = norm.exp - 18'(lz);
   end

   always_ff @(posedge clock) begin
      if (enable) norm_ff <= norm_in;
   end
endmodule
`default_nettype wire

FILE: design/edc_round.sv
// Stage three: shift, round to nearest-even and pack the double result, or pack the extended result.
`default_nettype none
module edc_round import edc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  enable,
   input  wire norm_type norm,
   output rsp_type    rsp_ff
);
   rsp_type rsp_in;
   logic [6:0] sh;
   logic [63:0] q, rem, half;
   logic [53:0] qr;
   logic signed [17:0] be;

   always_comb begin
      rsp_in = '0;
      q = '0; rem = '0; half = '0; qr = '0; be = norm.exp;
      sh = 7'd11;
      if (norm.exp < 18'sd1) begin
         sh = (norm.exp < -18'sd60) ? 7'd72 : 7'(18'sd12 - norm.exp);
      end
      if (sh > 7'd64) begin
         q = 64'd0;
      end else if (sh == 7'd64) begin
         q = {63'd0, norm.mant[63] && (norm.mant[62:0] != 63'd0)};
      end else begin
         q = norm.mant >> sh[5:0];
         rem = norm.mant & ((64'd1 << sh[5:0]) - 64'd1);
         half = 64'd1 << (sh[5:0] - 6'd1);
         if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      end
      qr = q[53:0];
      if (norm.op == OP_EXT_TO_DBL) begin
         if (norm.special) begin
            rsp_in.double_result = norm.special_val;
         end else if (norm.exp >= 18'sd1) begin
            if (qr[53]) begin
               qr = qr >> 1;
               be = be + 18'sd1;
            end
            if (be >= 18'sd2047)
               rsp_in.double_result = {norm.sign, 11'h7ff, 52'd0};
            else
               rsp_in.double_result = {norm.sign, be[10:0], qr[51:0]};
         end else begin
            rsp_in.double_result = {norm.sign, q[62:0]};
         end
      end else begin
         if (norm.special) begin
            rsp_in.ext_significand_out = norm.special_val;
            rsp_in.ext_sign_exponent_out = norm.special_se;
         end else begin
            rsp_in.ext_significand_out = norm.mant;
            rsp_in.ext_sign_exponent_out = {norm.sign, norm.exp[14:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire
